// File: design/euler_rotation_vector_transform_macros.svh
// Assertion macros used by the rotation block checker.
`ifndef EULER_ROTATION_VECTOR_TRANSFORM_MACROS_SVH
`define EULER_ROTATION_VECTOR_TRANSFORM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ERVT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ervt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ERVT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ervt: next-cycle check failed");

`endif

// File: design/ervt_pkg.sv
// Shared constants for the Euler rotation block.
package ervt_pkg;

	// Default parameter values
	localparam int COORD_WIDTH_DEF    = 32;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int ANGLE_WIDTH_DEF    = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 2'd3;

	// Q30 arithmetic of the sine/cosine unit
	localparam int Q30_W = 31;
	localparam logic [Q30_W-1:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [Q30_W-1:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [29:0]      Q30_EIGHTH  = 30'h2000_0000;

endpackage

// File: design/ervt_coef_builder.sv
// Configuration registers, sine/cosine sequencer and rotation matrix build.
module ervt_coef_builder #(
	parameter int COEF_FRAC_BITS = ervt_pkg::COEF_FRAC_BITS_DEF,
	parameter int ANGLE_WIDTH    = ervt_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ervt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ANGLE_WIDTH-1:0]              cfg_data,
	output logic                                inverse,
	output logic signed [COEF_FRAC_BITS+1:0]    coef [9]
);

	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int ACW   = 2 * CW + 1;
	localparam int QW    = ervt_pkg::Q30_W;
	localparam logic signed [CW-1:0] COEF_ONE = CW'(1) <<< COEF_FRAC_BITS;
	localparam logic signed [CW-1:0] COEF_MAX = {2'b01, {COEF_FRAC_BITS{1'b1}}};
	localparam logic signed [CW-1:0] COEF_MIN = {2'b10, {COEF_FRAC_BITS{1'b0}}};
	localparam logic signed [ACW-1:0] ACC_HALF = ACW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic [3:0] MSTEP_LAST = 4'd13;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_X    = 8'b0000_0010,
		ST_X2   = 8'b0000_0100,
		ST_PMUL = 8'b0000_1000,
		ST_PDIV = 8'b0001_0000,
		ST_SMUL = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_MAT  = 8'b1000_0000
	} bld_state_t;

	// Round a Q30 value half up to a coefficient
	function automatic logic signed [CW-1:0] to_coef(input logic [QW-1:0] v);
		logic [31:0] t;
		t = (32'({1'b0, v}) + (32'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
		return signed'(CW'(t));
	endfunction

	bld_state_t state_q;
	logic [ANGLE_WIDTH-1:0] yaw_q, pitch_q, roll_q;
	logic inv_q;
	logic [1:0] ang_idx_q;
	logic poly_q;
	logic [1:0] term_q;
	logic [QW-1:0] x_q, x2_q, p_q, s_q;
	logic [QW-1:0] div_quo_q;
	logic signed [CW-1:0] sin_q [3];
	logic signed [CW-1:0] cos_q [3];
	logic signed [CW-1:0] a_q [4];
	logic signed [CW-1:0] m_q [9];
	logic [3:0] mstep_q;
	logic signed [ACW-1:0] acc_q;

	// Fold the selected angle into the first eighth of a turn
	logic [ANGLE_WIDTH-1:0] ang_sel;
	logic [31:0] turn;
	logic [1:0] quad;
	logic [29:0] rem30;
	logic swap;
	logic [QW-1:0] r_fold;

	always_comb begin
		case (ang_idx_q)
			2'd0:    ang_sel = yaw_q;
			2'd1:    ang_sel = pitch_q;
			default: ang_sel = roll_q;
		endcase
	end

	assign turn   = 32'(ang_sel) << (32 - ANGLE_WIDTH);
	assign quad   = turn[31:30];
	assign rem30  = turn[29:0];
	assign swap   = rem30 > ervt_pkg::Q30_EIGHTH;
	assign r_fold = swap ? (ervt_pkg::Q30_ONE - {1'b0, rem30}) : {1'b0, rem30};

	// Taylor divisors as 2^pre * odd: quotient = ((n >> pre) * mul) >> post,
	// exact for every dividend below 2^30; sine terms then cosine terms
	logic [1:0] div_pre;
	logic [QW-1:0] div_mul;
	logic [5:0] div_post;

	always_comb begin
		case ({poly_q, term_q})
			3'b000: begin  // 72
				div_pre  = 2'd3;
				div_mul  = 31'd954437177;
				div_post = 6'd33;
			end
			3'b001: begin  // 42
				div_pre  = 2'd1;
				div_mul  = 31'd818089009;
				div_post = 6'd34;
			end
			3'b010: begin  // 20
				div_pre  = 2'd2;
				div_mul  = 31'd858993460;
				div_post = 6'd32;
			end
			3'b011: begin  // 6
				div_pre  = 2'd1;
				div_mul  = 31'd1431655766;
				div_post = 6'd32;
			end
			3'b100: begin  // 56
				div_pre  = 2'd3;
				div_mul  = 31'd1227133514;
				div_post = 6'd33;
			end
			3'b101: begin  // 30
				div_pre  = 2'd1;
				div_mul  = 31'd1145324613;
				div_post = 6'd34;
			end
			3'b110: begin  // 12
				div_pre  = 2'd2;
				div_mul  = 31'd1431655766;
				div_post = 6'd32;
			end
			default: begin  // 2
				div_pre  = 2'd1;
				div_mul  = 31'd1;
				div_post = 6'd0;
			end
		endcase
	end

	// Shared Q30 multiplier
	logic [QW-1:0] mul_a, mul_b, q30_p, div_res;
	logic [2*QW-1:0] mul_p;

	always_comb begin
		case (state_q)
			ST_X: begin
				mul_a = r_fold;
				mul_b = ervt_pkg::HALF_PI_Q30;
			end
			ST_X2: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_PMUL: begin
				mul_a = x2_q;
				mul_b = p_q;
			end
			ST_PDIV: begin
				mul_a = div_quo_q >> div_pre;
				mul_b = div_mul;
			end
			ST_SMUL: begin
				mul_a = x_q;
				mul_b = p_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign q30_p   = mul_p[QW+29:30];
	assign div_res = QW'(mul_p >> div_post);

	// Final sine/cosine with quadrant correction
	logic signed [CW-1:0] fs0, fc0, fs, fc, sn_fin, cs_fin;

	assign fs0 = to_coef(s_q);
	assign fc0 = to_coef(p_q);
	assign fs  = swap ? fc0 : fs0;
	assign fc  = swap ? fs0 : fc0;

	always_comb begin
		case (quad)
			2'd0: begin
				sn_fin = fs;
				cs_fin = fc;
			end
			2'd1: begin
				sn_fin = fc;
				cs_fin = -fs;
			end
			2'd2: begin
				sn_fin = -fs;
				cs_fin = -fc;
			end
			default: begin
				sn_fin = -fc;
				cs_fin = fs;
			end
		endcase
	end

	// Matrix product steps: operands, accumulate control, destination
	logic signed [CW-1:0] op_a, op_b;
	logic m_first, m_last, a_wr, m_wr;
	logic [1:0] a_idx;
	logic [3:0] m_idx;

	always_comb begin
		op_a    = sin_q[0];
		op_b    = cos_q[1];
		m_first = 1'b1;
		m_last  = 1'b1;
		a_wr    = 1'b0;
		m_wr    = 1'b0;
		a_idx   = 2'd0;
		m_idx   = 4'd0;
		case (mstep_q)
			4'd0: begin
				a_wr = 1'b1;
			end
			4'd1: begin
				op_b  = sin_q[1];
				a_wr  = 1'b1;
				a_idx = 2'd1;
			end
			4'd2: begin
				op_a  = cos_q[0];
				a_wr  = 1'b1;
				a_idx = 2'd2;
			end
			4'd3: begin
				op_a  = cos_q[0];
				op_b  = sin_q[1];
				a_wr  = 1'b1;
				a_idx = 2'd3;
			end
			4'd4: begin
				op_a   = cos_q[0];
				op_b   = cos_q[2];
				m_last = 1'b0;
			end
			4'd5: begin
				op_a    = a_q[1];
				op_b    = -sin_q[2];
				m_first = 1'b0;
				m_wr    = 1'b1;
				m_idx   = 4'd0;
			end
			4'd6: begin
				op_a   = cos_q[0];
				op_b   = sin_q[2];
				m_last = 1'b0;
			end
			4'd7: begin
				op_a    = a_q[1];
				op_b    = cos_q[2];
				m_first = 1'b0;
				m_wr    = 1'b1;
				m_idx   = 4'd2;
			end
			4'd8: begin
				op_a   = -sin_q[0];
				op_b   = cos_q[2];
				m_last = 1'b0;
			end
			4'd9: begin
				op_a    = a_q[3];
				op_b    = -sin_q[2];
				m_first = 1'b0;
				m_wr    = 1'b1;
				m_idx   = 4'd3;
			end
			4'd10: begin
				op_a   = -sin_q[0];
				op_b   = sin_q[2];
				m_last = 1'b0;
			end
			4'd11: begin
				op_a    = a_q[3];
				op_b    = cos_q[2];
				m_first = 1'b0;
				m_wr    = 1'b1;
				m_idx   = 4'd5;
			end
			4'd12: begin
				op_a  = cos_q[1];
				op_b  = -sin_q[2];
				m_wr  = 1'b1;
				m_idx = 4'd6;
			end
			default: begin
				op_a  = cos_q[1];
				op_b  = cos_q[2];
				m_wr  = 1'b1;
				m_idx = 4'd8;
			end
		endcase
	end

	// Accumulate, round half up and clamp to the coefficient range
	logic signed [2*CW-1:0] mprod;
	logic signed [ACW-1:0] acc_nx, rnd_full;
	logic signed [CW-1:0] coef_rnd;

	assign mprod    = op_a * op_b;
	assign acc_nx   = (m_first ? '0 : acc_q) + ACW'(mprod);
	assign rnd_full = (acc_nx + ACC_HALF) >>> COEF_FRAC_BITS;

	always_comb begin
		if (rnd_full > ACW'(COEF_MAX)) begin
			coef_rnd = COEF_MAX;
		end else if (rnd_full < ACW'(COEF_MIN)) begin
			coef_rnd = COEF_MIN;
		end else begin
			coef_rnd = rnd_full[CW-1:0];
		end
	end

	// Control sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			yaw_q     <= '0;
			pitch_q   <= '0;
			roll_q    <= '0;
			inv_q     <= 1'b0;
			ang_idx_q <= '0;
			poly_q    <= 1'b0;
			term_q    <= '0;
			mstep_q   <= '0;
			for (int i = 0; i < 9; i++) begin
				m_q[i] <= (i % 4 == 0) ? COEF_ONE : '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							ervt_pkg::CFG_YAW: begin
								yaw_q     <= cfg_data;
								ang_idx_q <= 2'd0;
								state_q   <= ST_X;
							end
							ervt_pkg::CFG_PITCH: begin
								pitch_q   <= cfg_data;
								ang_idx_q <= 2'd0;
								state_q   <= ST_X;
							end
							ervt_pkg::CFG_ROLL: begin
								roll_q    <= cfg_data;
								ang_idx_q <= 2'd0;
								state_q   <= ST_X;
							end
							default: begin
								inv_q <= cfg_data[0];
							end
						endcase
					end
				end
				ST_X: begin
					state_q <= ST_X2;
				end
				ST_X2: begin
					poly_q  <= 1'b0;
					term_q  <= '0;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					if (term_q == 2'd3) begin
						state_q <= poly_q ? ST_FIN : ST_SMUL;
					end else begin
						term_q  <= term_q + 1'b1;
						state_q <= ST_PMUL;
					end
				end
				ST_SMUL: begin
					poly_q  <= 1'b1;
					term_q  <= '0;
					state_q <= ST_PMUL;
				end
				ST_FIN: begin
					if (ang_idx_q == 2'd2) begin
						mstep_q <= '0;
						state_q <= ST_MAT;
					end else begin
						ang_idx_q <= ang_idx_q + 1'b1;
						state_q   <= ST_X;
					end
				end
				ST_MAT: begin
					if (m_wr) begin
						m_q[m_idx] <= coef_rnd;
					end
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == MSTEP_LAST) begin
						m_q[1]  <= a_q[0];
						m_q[4]  <= a_q[2];
						m_q[7]  <= -sin_q[1];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_X: begin
				x_q <= q30_p;
			end
			ST_X2: begin
				x2_q <= q30_p;
				p_q  <= ervt_pkg::Q30_ONE;
			end
			ST_PMUL: begin
				div_quo_q <= q30_p;
			end
			ST_PDIV: begin
				p_q <= ervt_pkg::Q30_ONE - div_res;
			end
			ST_SMUL: begin
				s_q <= q30_p;
				p_q <= ervt_pkg::Q30_ONE;
			end
			ST_FIN: begin
				sin_q[ang_idx_q] <= sn_fin;
				cos_q[ang_idx_q] <= cs_fin;
			end
			ST_MAT: begin
				acc_q <= acc_nx;
				if (a_wr) begin
					a_q[a_idx] <= coef_rnd;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign inverse   = inv_q;
	assign coef      = m_q;

endmodule

// File: design/euler_rotation_vector_transform.sv
// Top level: Euler-angle rotation of a stream of fixed-point 3-D vectors.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid/s_tready    tdata: vec_x, vec_y, vec_z
//   m_*       out        m_tvalid/m_tready    tdata: out_x, out_y, out_z; tuser: saturated
//   cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vector per cycle unless m_tready or a rebuild stalls it; a vector passes the
// input, product and result registers, each stage moving on when the next is free.
// An angle write recomputes the sines and cosines on one shared Q30 multiplier,
// dividing by reciprocal products, and rebuilds the matrix; cfg_ready and s_tready
// stay low. Reset loads the identity matrix and clears all angles and inverse mode.
module euler_rotation_vector_transform #(
	parameter int COORD_WIDTH    = ervt_pkg::COORD_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = ervt_pkg::COEF_FRAC_BITS_DEF,
	parameter int ANGLE_WIDTH    = ervt_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,  // vec_x, vec_y, vec_z, zero pad
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,  // out_x, out_y, out_z, zero pad
	output logic                                      m_tuser,  // saturated
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [ervt_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [ANGLE_WIDTH-1:0]                    cfg_data
);

	localparam int DW = ((3 * COORD_WIDTH + 7) / 8) * 8;
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int PW = CW + COORD_WIDTH;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] SAT_MAX = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SAT_MIN = -(SW'(1) <<< (COORD_WIDTH - 1));

	logic inverse;
	logic signed [CW-1:0] coef [9];

	ervt_coef_builder #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_builder (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.inverse(inverse),
		.coef(coef)
	);

	// Stage handshake: a stage takes data when empty or when it drains
	logic valid_s1, valid_s2, valid_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !valid_s3 || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1 && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= s_tvalid && s_tready;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Input register
	logic signed [COORD_WIDTH-1:0] vec_s1 [3];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int k = 0; k < 3; k++) begin
				vec_s1[k] <= signed'(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
			end
		end
	end

	// Products of matrix entries (transposed in inverse mode) and components
	logic signed [PW-1:0] prod_s2 [9];

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			logic signed [CW-1:0] c_sel;
			assign c_sel = inverse ? coef[k*3+i] : coef[i*3+k];
			always_ff @(posedge clk) begin
				if (rdy2) begin
					prod_s2[i*3+k] <= c_sel * vec_s1[k];
				end
			end
		end
	end

	// Row sums, floor shift and saturation
	logic signed [COORD_WIDTH-1:0] out_s3 [3];
	logic signed [COORD_WIDTH-1:0] res [3];
	logic [2:0] clip;
	logic sat_s3;

	for (genvar i = 0; i < 3; i++) begin : g_sum
		logic signed [SW-1:0] sum, shr;
		assign sum = SW'(prod_s2[i*3]) + SW'(prod_s2[i*3+1]) + SW'(prod_s2[i*3+2]);
		assign shr = sum >>> COEF_FRAC_BITS;
		always_comb begin
			if (shr > SAT_MAX) begin
				res[i]  = SAT_MAX[COORD_WIDTH-1:0];
				clip[i] = 1'b1;
			end else if (shr < SAT_MIN) begin
				res[i]  = SAT_MIN[COORD_WIDTH-1:0];
				clip[i] = 1'b1;
			end else begin
				res[i]  = shr[COORD_WIDTH-1:0];
				clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			out_s3 <= res;
			sat_s3 <= |clip;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = DW'({out_s3[2], out_s3[1], out_s3[0]});
	assign m_tuser  = sat_s3;

endmodule

// File: design/ervt_checker.sv
// Port-level checks for the rotation block, bound to its top level.
`include "euler_rotation_vector_transform_macros.svh"

module ervt_checker #(
	parameter int COORD_WIDTH    = ervt_pkg::COORD_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
	input logic                                m_tuser,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [ervt_pkg::CFG_IDX_W-1:0]      cfg_index
);

	// Hold a stalled result request
	`ERVT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`ERVT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

	// Input is closed while the matrix is rebuilt
	`ERVT_ASSERT_SAME(a_busy_blocks_in, !cfg_ready, !s_tready)

	// An angle write starts a rebuild at once
	`ERVT_ASSERT_NEXT(a_angle_starts_build,
		cfg_valid && cfg_ready && (cfg_index == ervt_pkg::CFG_YAW ||
		cfg_index == ervt_pkg::CFG_PITCH || cfg_index == ervt_pkg::CFG_ROLL),
		!cfg_ready && !s_tready)

endmodule

bind euler_rotation_vector_transform ervt_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_ervt_checker (.*);
